// ===== src/wbpp_pkg.sv =====
// Shared types and constants for the wall bounce path predictor.
// Used by wbpp_ctrl, wbpp_datapath and the top level; no dependencies.
package wbpp_pkg;

  // Coordinate and arithmetic widths
  localparam int CW    = 32;   // Q16.16 coordinate
  localparam int DW    = 33;   // coordinate difference
  localparam int SW    = 67;   // signed side value (cross product)
  localparam int MW    = 66;   // side value magnitude
  localparam int KW    = 34;   // scale factor magnitude (up to 3 * 2^32)
  localparam int OPW   = 35;   // multiplier operand
  localparam int PRW   = 70;   // multiplier product
  localparam int ACCW  = 104;  // accumulator
  localparam int DENW  = 67;   // divisor magnitude
  localparam int NW    = 100;  // dividend / quotient
  localparam int DCW   = 7;    // divider step counter
  localparam int OFFW  = 42;   // signed clamped offset
  localparam int LIMW  = 41;   // clamp magnitude
  localparam int CHW   = 33;   // multiplicand chunk
  localparam logic [LIMW-1:0] OFF_LIMIT = 41'h100_0000_0000;

  // Configuration register indexes
  localparam logic [2:0] CFG_BL_X = 3'd0;
  localparam logic [2:0] CFG_BL_Y = 3'd1;
  localparam logic [2:0] CFG_BR_X = 3'd2;
  localparam logic [2:0] CFG_BR_Y = 3'd3;
  localparam logic [2:0] CFG_LT_X = 3'd4;
  localparam logic [2:0] CFG_LT_Y = 3'd5;
  localparam logic [2:0] CFG_RT_X = 3'd6;
  localparam logic [2:0] CFG_RT_Y = 3'd7;

  // Wall code on the result port
  typedef enum logic [1:0] {
    WALL_LEFT   = 2'd0,
    WALL_RIGHT  = 2'd1,
    WALL_BOTTOM = 2'd2,
    WALL_NONE   = 2'd3
  } wall_code_e;

  // Wall under test, in test order
  typedef enum logic [1:0] {
    PROBE_LEFT,
    PROBE_BOTTOM,
    PROBE_RIGHT,
    PROBE_END
  } probe_e;

  // Coordinate sources for the difference operands
  typedef enum logic [3:0] {
    CO_ZERO,
    CO_Q1X,
    CO_Q1Y,
    CO_Q2X,
    CO_Q2Y,
    CO_W1X,
    CO_W1Y,
    CO_W2X,
    CO_W2Y
  } coord_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_LOAD_HI,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  // Cross product destinations
  typedef enum logic [2:0] {
    DST_S1,
    DST_S2,
    DST_T1,
    DST_T2,
    DST_EM
  } dst_e;

  // Scaled offset being computed
  typedef enum logic [1:0] {
    SEL_PX,
    SEL_PY,
    SEL_MX,
    SEL_MY
  } scale_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CROSS,
    ST_TEST,
    ST_SCALE,
    ST_DIV,
    ST_EMIT,
    ST_NONE,
    ST_NEXT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic       load_in;
    probe_e     wall;
    coord_e     ca;
    coord_e     cb;
    coord_e     cc;
    coord_e     cd;
    logic       mul_k;
    logic       num_hi;
    acc_op_e    acc_op;
    logic       store;
    dst_e       dst;
    logic       scale_setup;
    scale_e     sel;
    logic       div_start;
    logic       scale_store;
    logic       advance;
    logic       emit;
    logic       emit_none;
    wall_code_e code;
    logic [3:0] index;
    logic       last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic den_zero;
    logic div_done;
  } dp_status_t;

endpackage

// ===== src/wall_bounce_path_predictor.sv =====
// Wall bounce path predictor: tests the walls of a segment in turn and computes the
// contact point, one segment at a time. Each point needs two serial divisions
// (restoring divider), and two more for the mirrored segment unless it is the last;
// a full path has up to MAX_POINTS = 11 points. Results come one per strobe cycle
// and cannot be stalled. Reset clears control; corner registers reset
// to their default wall layout.
module wall_bounce_path_predictor import wbpp_pkg::*; #(
  parameter int MAX_POINTS = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [CW-1:0]        cfg_data_i,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] start_x_i,
  input  logic signed [CW-1:0] start_y_i,
  input  logic signed [CW-1:0] end_x_i,
  input  logic signed [CW-1:0] end_y_i,
  output logic                 strobe_o,
  output logic signed [CW-1:0] hit_x_o,
  output logic signed [CW-1:0] hit_y_o,
  output logic [1:0]           wall_o,
  output logic [3:0]           bounce_index_o,
  output logic                 last_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  wbpp_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  wbpp_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .strobe_o       (strobe_o),
    .hit_x_o        (hit_x_o),
    .hit_y_o        (hit_y_o),
    .wall_o         (wall_o),
    .bounce_index_o (bounce_index_o),
    .last_o         (last_o)
  );

endmodule

// ===== src/wbpp_datapath.sv =====
// Datapath of the wall bounce path predictor: configuration registers,
// segment registers, shared multiplier/accumulator, serial divider, result register.
// Depends on wbpp_pkg.
module wbpp_datapath import wbpp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [CW-1:0]         cfg_data_i,
  input  logic signed [CW-1:0]  start_x_i,
  input  logic signed [CW-1:0]  start_y_i,
  input  logic signed [CW-1:0]  end_x_i,
  input  logic signed [CW-1:0]  end_y_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output logic                  strobe_o,
  output logic signed [CW-1:0]  hit_x_o,
  output logic signed [CW-1:0]  hit_y_o,
  output logic [1:0]            wall_o,
  output logic [3:0]            bounce_index_o,
  output logic                  last_o
);

  function automatic logic signed [CW-1:0] pick(
    input coord_e c,
    input logic signed [CW-1:0] q1x, q1y, q2x, q2y, w1x, w1y, w2x, w2y
  );
    logic signed [CW-1:0] v;
    unique case (c)
      CO_Q1X:  v = q1x;
      CO_Q1Y:  v = q1y;
      CO_Q2X:  v = q2x;
      CO_Q2Y:  v = q2y;
      CO_W1X:  v = w1x;
      CO_W1Y:  v = w1y;
      CO_W2X:  v = w2x;
      CO_W2Y:  v = w2y;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Configuration registers (wall corners)
  logic signed [CW-1:0] bl_x_q, bl_y_q, br_x_q, br_y_q;
  logic signed [CW-1:0] lt_x_q, lt_y_q, rt_x_q, rt_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bl_x_q <= 32'sd65536;
      bl_y_q <= -32'sd65536;
      br_x_q <= 32'sd3538944;
      br_y_q <= -32'sd65536;
      lt_x_q <= 32'sd65536;
      lt_y_q <= 32'sd3932160;
      rt_x_q <= 32'sd3538944;
      rt_y_q <= 32'sd3932160;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BL_X: bl_x_q <= cfg_data_i;
        CFG_BL_Y: bl_y_q <= cfg_data_i;
        CFG_BR_X: br_x_q <= cfg_data_i;
        CFG_BR_Y: br_y_q <= cfg_data_i;
        CFG_LT_X: lt_x_q <= cfg_data_i;
        CFG_LT_Y: lt_y_q <= cfg_data_i;
        CFG_RT_X: rt_x_q <= cfg_data_i;
        CFG_RT_Y: rt_y_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Wall endpoints for the wall under test
  logic signed [CW-1:0] w1x, w1y, w2x, w2y;

  always_comb begin
    unique case (cmd_i.wall)
      PROBE_LEFT: begin
        w1x = bl_x_q; w1y = bl_y_q; w2x = lt_x_q; w2y = lt_y_q;
      end
      PROBE_BOTTOM: begin
        w1x = bl_x_q; w1y = bl_y_q; w2x = br_x_q; w2y = br_y_q;
      end
      PROBE_RIGHT, PROBE_END: begin
        w1x = br_x_q; w1y = br_y_q; w2x = rt_x_q; w2y = rt_y_q;
      end
      default: begin
        w1x = br_x_q; w1y = br_y_q; w2x = rt_x_q; w2y = rt_y_q;
      end
    endcase
  end

  // Current segment and computed points
  logic signed [CW-1:0] q1x_q, q1y_q, q2x_q, q2y_q;
  logic signed [CW-1:0] px_q, py_q, mx_q, my_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      q1x_q <= start_x_i;
      q1y_q <= start_y_i;
      q2x_q <= end_x_i;
      q2y_q <= end_y_i;
    end else if (cmd_i.advance) begin
      q1x_q <= mx_q;
      q1y_q <= my_q;
      q2x_q <= px_q;
      q2y_q <= py_q;
    end
  end

  // Difference operands
  logic signed [CW-1:0] ca, cb, cc, cd;
  logic signed [DW-1:0] diff_a, diff_b;

  assign ca = pick(cmd_i.ca, q1x_q, q1y_q, q2x_q, q2y_q, w1x, w1y, w2x, w2y);
  assign cb = pick(cmd_i.cb, q1x_q, q1y_q, q2x_q, q2y_q, w1x, w1y, w2x, w2y);
  assign cc = pick(cmd_i.cc, q1x_q, q1y_q, q2x_q, q2y_q, w1x, w1y, w2x, w2y);
  assign cd = pick(cmd_i.cd, q1x_q, q1y_q, q2x_q, q2y_q, w1x, w1y, w2x, w2y);
  assign diff_a = DW'(ca) - DW'(cb);
  assign diff_b = DW'(cc) - DW'(cd);

  // Scale operands, set up per offset
  logic [KW-1:0]        k_mag_q;
  logic [MW-1:0]        num_mag_q;
  logic [DENW-1:0]      den_mag_q;
  logic                 neg_q;
  logic signed [CW-1:0] base_q;
  logic [MW-1:0]        em_q;

  // Shared multiplier, registered product
  logic [CHW-1:0]        chunk;
  logic signed [OPW-1:0] op_a, op_b;
  logic signed [PRW-1:0] prod_d, prod_q;

  assign chunk  = cmd_i.num_hi ? num_mag_q[2*CHW-1:CHW] : num_mag_q[CHW-1:0];
  assign op_a   = cmd_i.mul_k ? $signed({1'b0, k_mag_q}) : OPW'(diff_a);
  assign op_b   = cmd_i.mul_k ? $signed({2'b00, chunk}) : OPW'(diff_b);
  assign prod_d = op_a * op_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Accumulator
  logic signed [ACCW-1:0] acc_q, acc_d, prod_ext;

  assign prod_ext = ACCW'(prod_q);

  always_comb begin
    unique case (cmd_i.acc_op)
      ACC_LOAD:    acc_d = prod_ext;
      ACC_LOAD_HI: acc_d = prod_ext <<< CHW;
      ACC_ADD:     acc_d = acc_q + prod_ext;
      ACC_SUB:     acc_d = acc_q - prod_ext;
      default:     acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Side values of the wall test
  logic signed [SW-1:0] s1_q, s2_q, t1_q, t2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      unique case (cmd_i.dst)
        DST_S1:  s1_q <= acc_q[SW-1:0];
        DST_S2:  s2_q <= acc_q[SW-1:0];
        DST_T1:  t1_q <= acc_q[SW-1:0];
        DST_T2:  t2_q <= acc_q[SW-1:0];
        DST_EM:  em_q <= acc_q[MW-1:0];
        default: ;
      endcase
    end
  end

  // Hit test: wall ends not strictly on one side, end closer than start
  logic [SW-1:0]  s1_abs, t1_abs, t2_abs;
  logic           same_side;
  logic signed [SW:0] den_int;
  logic [SW:0]    den_abs;

  assign s1_abs    = s1_q[SW-1] ? SW'(-s1_q) : SW'(s1_q);
  assign t1_abs    = t1_q[SW-1] ? SW'(-t1_q) : SW'(t1_q);
  assign t2_abs    = t2_q[SW-1] ? SW'(-t2_q) : SW'(t2_q);
  assign same_side = (s1_q != '0) && (s2_q != '0) && (s1_q[SW-1] == s2_q[SW-1]);
  // determinant of segment and wall equals s2 - s1
  assign den_int   = (SW+1)'(s2_q) - (SW+1)'(s1_q);
  assign den_abs   = den_int[SW] ? (SW+1)'(-den_int) : (SW+1)'(den_int);

  assign status_o.hit      = !same_side && (t2_abs[MW-1:0] < t1_abs[MW-1:0]);
  assign status_o.den_zero = (den_int == '0);

  // Wall vector
  logic signed [DW-1:0]  ex, ey;
  logic signed [OPW-1:0] k_s, k_abs;

  assign ex = DW'(w2x) - DW'(w1x);
  assign ey = DW'(w2y) - DW'(w1y);

  always_comb begin
    unique case (cmd_i.sel)
      SEL_PX:  k_s = OPW'(ex);
      SEL_PY:  k_s = OPW'(ey);
      SEL_MX:  k_s = (OPW'(ey) <<< 1) + OPW'(ey);
      default: k_s = -((OPW'(ex) <<< 1) + OPW'(ex));
    endcase
  end

  assign k_abs = k_s[OPW-1] ? -k_s : k_s;

  // Load operands for one scaled offset
  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_setup) begin
      k_mag_q <= k_abs[KW-1:0];
      unique case (cmd_i.sel)
        SEL_PX, SEL_PY: begin
          num_mag_q <= s1_abs[MW-1:0];
          den_mag_q <= den_abs[DENW-1:0];
          neg_q     <= k_s[OPW-1] ^ ~s1_q[SW-1] ^ den_int[SW];
          base_q    <= (cmd_i.sel == SEL_PX) ? w1x : w1y;
        end
        default: begin
          num_mag_q <= t1_abs[MW-1:0];
          den_mag_q <= {em_q, 1'b0};
          neg_q     <= k_s[OPW-1] ^ t1_q[SW-1];
          base_q    <= (cmd_i.sel == SEL_MX) ? q1x_q : q1y_q;
        end
      endcase
    end
  end

  // Restoring divider, one quotient bit per cycle
  logic [NW-1:0]   nq_q;
  logic [DENW-1:0] rem_q;
  logic [DCW-1:0]  div_cnt_q;
  logic            div_busy_q;
  logic [DENW:0]   rem_sh, rem_sub;
  logic            rem_ge;

  assign rem_sh  = {rem_q, nq_q[NW-1]};
  assign rem_ge  = rem_sh >= {1'b0, den_mag_q};
  assign rem_sub = rem_sh - {1'b0, den_mag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= DCW'(NW);
    end else if (div_busy_q) begin
      div_cnt_q  <= div_cnt_q - 1'b1;
      div_busy_q <= (div_cnt_q != DCW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      nq_q  <= acc_q[NW-1:0];
      rem_q <= '0;
    end else if (div_busy_q) begin
      nq_q  <= {nq_q[NW-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[DENW-1:0] : rem_sh[DENW-1:0];
    end
  end

  assign status_o.div_done = !div_busy_q;

  // Round half up, clamp, apply sign, add base, saturate
  logic                  round_up;
  logic [NW:0]           q_rnd;
  logic [LIMW-1:0]       q_clamp;
  logic signed [OFFW-1:0] offset;
  logic signed [CW+10:0] sum;
  logic signed [CW-1:0]  sum_sat;

  assign round_up = {rem_q, 1'b0} >= {1'b0, den_mag_q};
  assign q_rnd    = {1'b0, nq_q} + (NW+1)'(round_up);
  assign q_clamp  = (q_rnd > (NW+1)'(OFF_LIMIT)) ? OFF_LIMIT : q_rnd[LIMW-1:0];
  assign offset   = neg_q ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
  assign sum      = (CW+11)'(base_q) + (CW+11)'(offset);

  always_comb begin
    if (sum > (CW+11)'(32'sh7FFF_FFFF)) begin
      sum_sat = 32'sh7FFF_FFFF;
    end else if (sum < -(CW+11)'(33'sh0_8000_0000)) begin
      sum_sat = 32'sh8000_0000;
    end else begin
      sum_sat = sum[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_store) begin
      unique case (cmd_i.sel)
        SEL_PX:  px_q <= sum_sat;
        SEL_PY:  py_q <= sum_sat;
        SEL_MX:  mx_q <= sum_sat;
        default: my_q <= sum_sat;
      endcase
    end
  end

  // Result register
  logic strobe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit || cmd_i.emit_none;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit || cmd_i.emit_none) begin
      hit_x_o        <= cmd_i.emit_none ? '0 : px_q;
      hit_y_o        <= cmd_i.emit_none ? '0 : py_q;
      wall_o         <= cmd_i.code;
      bounce_index_o <= cmd_i.index;
      last_o         <= cmd_i.last;
    end
  end

  assign strobe_o = strobe_q;

  // Checks
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> div_cnt_q != '0)
    else $error("divider busy with zero step count");

  a_div_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> div_busy_q)
    else $error("divider did not start");

  a_store_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scale_store |-> !div_busy_q)
    else $error("offset stored while divider still running");

endmodule

// ===== src/wbpp_ctrl.sv =====
// Controller of the wall bounce path predictor: sequences wall tests,
// intersection and mirror offsets, and result requests. Depends on wbpp_pkg.
module wbpp_ctrl import wbpp_pkg::*; #(
  parameter int MAX_POINTS = 11
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int CNTW = $clog2(MAX_POINTS + 1);

  state_e          state_q, state_d;
  logic [2:0]      step_q, step_d;
  dst_e            idx_q, idx_d;
  scale_e          sel_q, sel_d;
  probe_e          probe_q, probe_d;
  probe_e          prev_q, prev_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      idx_q   <= DST_S1;
      sel_q   <= SEL_PX;
      probe_q <= PROBE_LEFT;
      prev_q  <= PROBE_END;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      sel_q   <= sel_d;
      probe_q <= probe_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
    end
  end

  // Operand coordinates of the two products of each cross product
  coord_e m0a, m0b, m0c, m0d, m1a, m1b, m1c, m1d;

  always_comb begin
    unique case (idx_q)
      DST_S1, DST_S2: begin
        m0a = CO_Q2X; m0b = CO_Q1X;
        m0c = (idx_q == DST_S1) ? CO_W1Y : CO_W2Y; m0d = CO_Q1Y;
        m1a = CO_Q2Y; m1b = CO_Q1Y;
        m1c = (idx_q == DST_S1) ? CO_W1X : CO_W2X; m1d = CO_Q1X;
      end
      DST_T1, DST_T2: begin
        m0a = CO_W2X; m0b = CO_W1X;
        m0c = (idx_q == DST_T1) ? CO_Q1Y : CO_Q2Y; m0d = CO_W1Y;
        m1a = CO_W2Y; m1b = CO_W1Y;
        m1c = (idx_q == DST_T1) ? CO_Q1X : CO_Q2X; m1d = CO_W1X;
      end
      default: begin
        m0a = CO_W2X; m0b = CO_W1X; m0c = CO_W2X; m0d = CO_W1X;
        m1a = CO_W2Y; m1b = CO_W1Y; m1c = CO_W2Y; m1d = CO_W1Y;
      end
    endcase
  end

  logic [CNTW:0]   cnt_inc;
  logic            at_limit;
  logic [CNTW+3:0] cnt_ext;

  assign cnt_inc  = {1'b0, cnt_q} + 1'b1;
  assign at_limit = cnt_inc >= (CNTW+1)'(MAX_POINTS);
  assign cnt_ext  = {4'b0000, cnt_q};

  // Next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    idx_d   = idx_q;
    sel_d   = sel_q;
    probe_d = probe_q;
    prev_d  = prev_q;
    cnt_d   = cnt_q;
    cmd_o       = '0;
    cmd_o.wall  = probe_q;
    cmd_o.sel   = sel_q;
    cmd_o.dst   = idx_q;
    cmd_o.index = cnt_ext[3:0];

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load_in = 1'b1;
          probe_d = PROBE_LEFT;
          prev_d  = PROBE_END;
          cnt_d   = '0;
          state_d = ST_PROBE;
        end
      end

      // pick the next wall, skipping the one just left
      ST_PROBE: begin
        if (probe_q == PROBE_END) begin
          state_d = ST_NONE;
        end else if (probe_q == prev_q) begin
          probe_d = probe_e'(probe_q + 2'd1);
        end else begin
          idx_d   = DST_S1;
          step_d  = '0;
          state_d = ST_CROSS;
        end
      end

      // one cross product: two products, combine, store
      ST_CROSS: begin
        step_d = step_q + 3'd1;
        unique case (step_q)
          3'd0: begin
            cmd_o.ca = m0a; cmd_o.cb = m0b; cmd_o.cc = m0c; cmd_o.cd = m0d;
          end
          3'd1: begin
            cmd_o.ca = m1a; cmd_o.cb = m1b; cmd_o.cc = m1c; cmd_o.cd = m1d;
            cmd_o.acc_op = ACC_LOAD;
          end
          3'd2: begin
            cmd_o.acc_op = (idx_q == DST_EM) ? ACC_ADD : ACC_SUB;
          end
          default: begin
            cmd_o.store = 1'b1;
            step_d = '0;
            if (idx_q == DST_EM) begin
              sel_d   = SEL_MX;
              state_d = ST_SCALE;
            end else if (idx_q == DST_T2) begin
              state_d = ST_TEST;
            end else begin
              idx_d = dst_e'(idx_q + 3'd1);
            end
          end
        endcase
      end

      ST_TEST: begin
        if (!status_i.hit) begin
          probe_d = probe_e'(probe_q + 2'd1);
          state_d = ST_PROBE;
        end else if (status_i.den_zero) begin
          state_d = ST_NONE;
        end else begin
          sel_d   = SEL_PX;
          step_d  = '0;
          state_d = ST_SCALE;
        end
      end

      // scaled offset: k * |num| in two partial products, then divide
      ST_SCALE: begin
        step_d = step_q + 3'd1;
        unique case (step_q)
          3'd0: cmd_o.scale_setup = 1'b1;
          3'd1: begin
            cmd_o.mul_k  = 1'b1;
            cmd_o.num_hi = 1'b1;
          end
          3'd2: begin
            cmd_o.mul_k  = 1'b1;
            cmd_o.acc_op = ACC_LOAD_HI;
          end
          3'd3: cmd_o.acc_op = ACC_ADD;
          default: begin
            cmd_o.div_start = 1'b1;
            step_d  = '0;
            state_d = ST_DIV;
          end
        endcase
      end

      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.scale_store = 1'b1;
          step_d = '0;
          unique case (sel_q)
            SEL_PX: begin
              sel_d   = SEL_PY;
              state_d = ST_SCALE;
            end
            SEL_PY: state_d = ST_EMIT;
            SEL_MX: begin
              sel_d   = SEL_MY;
              state_d = ST_SCALE;
            end
            default: state_d = ST_NEXT;
          endcase
        end
      end

      // contact point request
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (probe_q == PROBE_BOTTOM) begin
          cmd_o.code = WALL_BOTTOM;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          cmd_o.code = (probe_q == PROBE_LEFT) ? WALL_LEFT : WALL_RIGHT;
          cmd_o.last = at_limit;
          if (at_limit) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d   = cnt_inc[CNTW-1:0];
            idx_d   = DST_EM;
            step_d  = '0;
            state_d = ST_CROSS;
          end
        end
      end

      // new segment: mirrored start to contact point
      ST_NEXT: begin
        cmd_o.advance = 1'b1;
        prev_d  = probe_q;
        probe_d = PROBE_LEFT;
        state_d = ST_PROBE;
      end

      ST_NONE: begin
        cmd_o.emit_none = 1'b1;
        cmd_o.code      = WALL_NONE;
        cmd_o.last      = 1'b1;
        state_d         = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNTW'(MAX_POINTS))
    else $error("point count beyond limit");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.emit, cmd_o.emit_none, cmd_o.load_in, cmd_o.advance}))
    else $error("conflicting segment commands");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !status_i.div_done) |=> state_q == ST_DIV)
    else $error("left divide wait early");

endmodule
